### hdl/quad_dewarp_address_gen_defines.svh
// Assertion macros for the quad dewarp address generator.
// Expects clk_i and rst_ni in the scope that uses them.
`ifndef QUAD_DEWARP_ADDRESS_GEN_DEFINES_SVH
`define QUAD_DEWARP_ADDRESS_GEN_DEFINES_SVH

// Condition holds at every rising clock edge outside reset.
`define QDW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define QDW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/qdw_pkg.sv
// Shared constants, register indexes and payload types of the quad dewarp
// address generator. No dependencies.
package qdw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_DIM_DEF   = 4096;
  localparam int DIV_STEP      = 4;     // quotient bits per divider stage

  localparam int COORD_W    = 12;
  localparam int DIM_W      = 13;
  localparam int CORNER_W   = 24;
  localparam int ADDR_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT = 3'd5;

  localparam logic [DIM_W-1:0]    WIDTH_RST        = 13'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST       = 13'd480;
  localparam logic [CORNER_W-1:0] TOP_LEFT_RST     = 24'd0;
  localparam logic [CORNER_W-1:0] TOP_RIGHT_RST    = 24'd639;
  localparam logic [CORNER_W-1:0] BOTTOM_RIGHT_RST = 24'd1962623;
  localparam logic [CORNER_W-1:0] BOTTOM_LEFT_RST  = 24'd1961984;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [ADDR_W-1:0]  src_address;
    logic               out_of_range;
  } pix_out_t;

endpackage

### hdl/qdw_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from qdw_pkg.
interface qdw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/qdw_div.sv
// Pipelined restoring unsigned divider, DIV_STEP quotient bits per stage,
// with a tag carried alongside. Depends on qdw_pkg.
module qdw_div import qdw_pkg::*; #(
  parameter int DW   = 28,
  parameter int VW   = DIM_W,
  parameter int TW   = 1,
  parameter int STEP = DIV_STEP
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [DW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int NS = (DW + STEP - 1) / STEP;
  localparam int PW = NS * STEP;

  logic          vld_q [NS];
  logic [VW-1:0] rem_q [NS];
  logic [PW-1:0] dq_q  [NS];
  logic [VW-1:0] den_q [NS];
  logic [TW-1:0] tag_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          vld_in;
    logic [VW-1:0] rem_in;
    logic [PW-1:0] dq_in;
    logic [VW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [VW-1:0] rem_d;
    logic [PW-1:0] dq_d;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign rem_in = '0;
      assign dq_in  = PW'(num_i);
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign rem_in = rem_q[s-1];
      assign dq_in  = dq_q[s-1];
      assign den_in = den_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_comb begin
      logic [VW:0]   shifted;
      logic [VW+1:0] trial;
      rem_d = rem_in;
      dq_d  = dq_in;
      for (int b = 0; b < STEP; b++) begin
        shifted = {rem_d, dq_d[PW-1]};
        trial   = {1'b0, shifted} - {2'b00, den_in};
        if (!trial[VW+1]) begin
          rem_d = trial[VW-1:0];
        end else begin
          rem_d = shifted[VW-1:0];
        end
        dq_d = {dq_d[PW-2:0], ~trial[VW+1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        dq_q[s]  <= dq_d;
        den_q[s] <= den_in;
        tag_q[s] <= tag_in;
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign quo_o = dq_q[NS-1][DW-1:0];
  assign tag_o = tag_q[NS-1];

endmodule

### hdl/quad_dewarp_address_gen.sv
// Quad dewarp address generator: maps an output pixel (row, column) to the
// source pixel, truncated toward zero, inside a quadrilateral set by four corner
// registers, and to its linear address src_y * image_width + src_x. One item is
// taken per cycle while the output is not stalled, and results leave in order;
// the pipeline runs through two pipelined dividers (row/height and span*col/width,
// four quotient bits per stage). A stalled output freezes the whole pipeline.
// Sources outside the image raise out_of_range and give address zero. Registers
// must be written only while the pipeline is empty; the block does not enforce it.
`include "quad_dewarp_address_gen_defines.svh"

module quad_dewarp_address_gen import qdw_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  qdw_stream_if.sink            in_ch,
  qdw_stream_if.source          out_ch
);

  // Fixed-point widths, all but LW following FRAC_BITS.
  localparam int F   = FRAC_BITS;
  localparam int SW  = COORD_W + F;   // row step, unsigned
  localparam int PRW = SW + 14;       // corner delta * step, signed
  localparam int EW  = F + 27;        // edge point, signed
  localparam int DW  = EW + 1;        // span right - left, signed
  localparam int MW  = DW + 13;       // span * col, signed
  localparam int NW  = MW;            // magnitude into divider
  localparam int FW  = NW + 2;        // interpolated coordinate, signed
  localparam int IW  = FW - F;        // integer part magnitude
  localparam int LW  = COORD_W + DIM_W + 1;

  // ---------------- configuration registers ----------------
  logic [DIM_W-1:0]    width_q, height_q;
  logic [CORNER_W-1:0] tl_q, tr_q, br_q, bl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      tl_q     <= TOP_LEFT_RST;
      tr_q     <= TOP_RIGHT_RST;
      br_q     <= BOTTOM_RIGHT_RST;
      bl_q     <= BOTTOM_LEFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WIDTH:        width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:       height_q <= cfg_data_i[DIM_W-1:0];
        REG_TOP_LEFT:     tl_q     <= cfg_data_i;
        REG_TOP_RIGHT:    tr_q     <= cfg_data_i;
        REG_BOTTOM_RIGHT: br_q     <= cfg_data_i;
        REG_BOTTOM_LEFT:  bl_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero size divides by one (result is then always out of range)
  logic [DIM_W-1:0] wdiv, hdiv;
  assign wdiv = (width_q == '0) ? DIM_W'(1) : width_q;
  assign hdiv = (height_q == '0) ? DIM_W'(1) : height_q;

  logic [COORD_W-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
  assign x1 = tl_q[11:0];  assign y1 = tl_q[23:12];
  assign x2 = tr_q[11:0];  assign y2 = tr_q[23:12];
  assign x3 = br_q[11:0];  assign y3 = br_q[23:12];
  assign x4 = bl_q[11:0];  assign y4 = bl_q[23:12];

  // edge deltas, signed
  logic signed [DIM_W-1:0] dxl, dyl, dxr, dyr;
  assign dxl = $signed({1'b0, x4}) - $signed({1'b0, x1});
  assign dyl = $signed({1'b0, y4}) - $signed({1'b0, y1});
  assign dxr = $signed({1'b0, x3}) - $signed({1'b0, x2});
  assign dyr = $signed({1'b0, y3}) - $signed({1'b0, y2});

  // global advance: everything moves unless the output is held
  logic out_vld_q;
  logic adv;
  assign adv         = !out_vld_q || out_ch.ready;
  assign in_ch.ready = adv;

  // ---------------- stage 0: input register ----------------
  logic               s0_vld_q;
  logic [COORD_W-1:0] s0_row_q, s0_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (adv) s0_vld_q <= in_ch.valid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_row_q <= in_ch.data.out_row;
      s0_col_q <= in_ch.data.out_col;
    end
  end

  // ---------------- row step = (row << F) / height ----------------
  logic               dh_vld;
  logic [SW-1:0]      dh_quo;
  logic [COORD_W-1:0] dh_col;

  qdw_div #(.DW(SW), .VW(DIM_W), .TW(COORD_W), .STEP(DIV_STEP)) u_div_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s0_vld_q),
    .num_i  ({s0_row_q, F'(0)}),
    .den_i  (hdiv),
    .tag_i  (s0_col_q),
    .vld_o  (dh_vld),
    .quo_o  (dh_quo),
    .tag_o  (dh_col)
  );

  // ---------------- stage 1: edge products ----------------
  logic                  s1_vld_q;
  logic [COORD_W-1:0]    s1_col_q;
  logic signed [PRW-1:0] s1_pxl_q, s1_pyl_q, s1_pxr_q, s1_pyr_q;
  logic signed [SW:0]    step_s;
  assign step_s = $signed({1'b0, dh_quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else if (adv) s1_vld_q <= dh_vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_col_q <= dh_col;
      s1_pxl_q <= PRW'(dxl) * PRW'(step_s);
      s1_pyl_q <= PRW'(dyl) * PRW'(step_s);
      s1_pxr_q <= PRW'(dxr) * PRW'(step_s);
      s1_pyr_q <= PRW'(dyr) * PRW'(step_s);
    end
  end

  // ---------------- stage 2: edge points ----------------
  logic                 s2_vld_q;
  logic [COORD_W-1:0]   s2_col_q;
  logic signed [EW-1:0] s2_lx_q, s2_ly_q, s2_rx_q, s2_ry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else if (adv) s2_vld_q <= s1_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_col_q <= s1_col_q;
      s2_lx_q  <= (EW'($signed({1'b0, x1})) <<< F) + EW'(s1_pxl_q);
      s2_ly_q  <= (EW'($signed({1'b0, y1})) <<< F) + EW'(s1_pyl_q);
      s2_rx_q  <= (EW'($signed({1'b0, x2})) <<< F) + EW'(s1_pxr_q);
      s2_ry_q  <= (EW'($signed({1'b0, y2})) <<< F) + EW'(s1_pyr_q);
    end
  end

  // ---------------- stage 3: span ----------------
  logic                 s3_vld_q;
  logic [COORD_W-1:0]   s3_col_q;
  logic signed [EW-1:0] s3_lx_q, s3_ly_q;
  logic signed [DW-1:0] s3_dx_q, s3_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else if (adv) s3_vld_q <= s2_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_col_q <= s2_col_q;
      s3_lx_q  <= s2_lx_q;
      s3_ly_q  <= s2_ly_q;
      s3_dx_q  <= DW'(s2_rx_q) - DW'(s2_lx_q);
      s3_dy_q  <= DW'(s2_ry_q) - DW'(s2_ly_q);
    end
  end

  // ---------------- stage 4: span * col ----------------
  logic                 s4_vld_q;
  logic signed [EW-1:0] s4_lx_q, s4_ly_q;
  logic signed [MW-1:0] s4_mx_q, s4_my_q;
  logic signed [COORD_W:0] col_s;
  assign col_s = $signed({1'b0, s3_col_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else if (adv) s4_vld_q <= s3_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_lx_q <= s3_lx_q;
      s4_ly_q <= s3_ly_q;
      s4_mx_q <= MW'(s3_dx_q) * MW'(col_s);
      s4_my_q <= MW'(s3_dy_q) * MW'(col_s);
    end
  end

  // ---------------- stage 5: sign / magnitude for the dividers ----------------
  logic                 s5_vld_q;
  logic signed [EW-1:0] s5_lx_q, s5_ly_q;
  logic                 s5_negx_q, s5_negy_q;
  logic [NW-1:0]        s5_magx_q, s5_magy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else if (adv) s5_vld_q <= s4_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_lx_q   <= s4_lx_q;
      s5_ly_q   <= s4_ly_q;
      s5_negx_q <= s4_mx_q[MW-1];
      s5_negy_q <= s4_my_q[MW-1];
      s5_magx_q <= s4_mx_q[MW-1] ? NW'(-s4_mx_q) : NW'(s4_mx_q);
      s5_magy_q <= s4_my_q[MW-1] ? NW'(-s4_my_q) : NW'(s4_my_q);
    end
  end

  // ---------------- span * col / width, truncating toward zero ----------------
  logic          divx_vld, divy_vld;
  logic [NW-1:0] divx_quo, divy_quo;
  logic [EW:0]   divx_tag, divy_tag;

  qdw_div #(.DW(NW), .VW(DIM_W), .TW(EW + 1), .STEP(DIV_STEP)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s5_vld_q),
    .num_i  (s5_magx_q),
    .den_i  (wdiv),
    .tag_i  ({s5_negx_q, s5_lx_q}),
    .vld_o  (divx_vld),
    .quo_o  (divx_quo),
    .tag_o  (divx_tag)
  );

  qdw_div #(.DW(NW), .VW(DIM_W), .TW(EW + 1), .STEP(DIV_STEP)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s5_vld_q),
    .num_i  (s5_magy_q),
    .den_i  (wdiv),
    .tag_i  ({s5_negy_q, s5_ly_q}),
    .vld_o  (divy_vld),
    .quo_o  (divy_quo),
    .tag_o  (divy_tag)
  );

  // ---------------- stage 6: coordinate = left + signed quotient ----------------
  logic                 s6_vld_q;
  logic signed [FW-1:0] s6_fx_q, s6_fy_q;
  logic signed [FW-1:0] qx_s, qy_s;
  assign qx_s = FW'($signed({1'b0, divx_quo}));
  assign qy_s = FW'($signed({1'b0, divy_quo}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else if (adv) s6_vld_q <= divx_vld;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_fx_q <= FW'($signed(divx_tag[EW-1:0])) + (divx_tag[EW] ? -qx_s : qx_s);
      s6_fy_q <= FW'($signed(divy_tag[EW-1:0])) + (divy_tag[EW] ? -qy_s : qy_s);
    end
  end

  // ---------------- stage 7: integer part, toward zero ----------------
  logic          s7_vld_q;
  logic          s7_negx_q, s7_negy_q;
  logic [IW-1:0] s7_imx_q, s7_imy_q;
  logic [FW-1:0] magfx, magfy;
  assign magfx = s6_fx_q[FW-1] ? FW'(-s6_fx_q) : FW'(s6_fx_q);
  assign magfy = s6_fy_q[FW-1] ? FW'(-s6_fy_q) : FW'(s6_fy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_vld_q <= 1'b0;
    else if (adv) s7_vld_q <= s6_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_negx_q <= s6_fx_q[FW-1];
      s7_negy_q <= s6_fy_q[FW-1];
      s7_imx_q  <= magfx[FW-1:F];
      s7_imy_q  <= magfy[FW-1:F];
    end
  end

  // ---------------- stage 8: range check and clamp ----------------
  logic               s8_vld_q;
  logic               s8_bad_q;
  logic [COORD_W-1:0] s8_ox_q, s8_oy_q;
  logic               sx_neg, sy_neg, bad_d;
  logic [COORD_W-1:0] ox_d, oy_d;

  always_comb begin
    // a negative coordinate whose integer part truncates to zero is zero
    sx_neg = s7_negx_q && (s7_imx_q != '0);
    sy_neg = s7_negy_q && (s7_imy_q != '0);
    bad_d  = sx_neg || sy_neg ||
             (s7_imx_q >= IW'(width_q)) || (s7_imy_q >= IW'(height_q)) ||
             (s7_imx_q >= IW'(MAX_DIM)) || (s7_imy_q >= IW'(MAX_DIM));
    if (sx_neg) ox_d = '0;
    else if (s7_imx_q > IW'(COORD_MAX)) ox_d = COORD_MAX;
    else ox_d = s7_imx_q[COORD_W-1:0];
    if (sy_neg) oy_d = '0;
    else if (s7_imy_q > IW'(COORD_MAX)) oy_d = COORD_MAX;
    else oy_d = s7_imy_q[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s8_vld_q <= 1'b0;
    else if (adv) s8_vld_q <= s7_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_bad_q <= bad_d;
      s8_ox_q  <= ox_d;
      s8_oy_q  <= oy_d;
    end
  end

  // ---------------- stage 9: address, output register ----------------
  logic [COORD_W-1:0] out_x_q, out_y_q;
  logic [ADDR_W-1:0]  out_addr_q;
  logic               out_bad_q;
  logic [LW-1:0]      lin_d;
  assign lin_d = LW'(s8_oy_q) * LW'(width_q) + LW'(s8_ox_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (adv) out_vld_q <= s8_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_x_q    <= s8_ox_q;
      out_y_q    <= s8_oy_q;
      out_bad_q  <= s8_bad_q;
      out_addr_q <= s8_bad_q ? '0 : lin_d[ADDR_W-1:0];
    end
  end

  assign out_ch.valid            = out_vld_q;
  assign out_ch.data.src_x       = out_x_q;
  assign out_ch.data.src_y       = out_y_q;
  assign out_ch.data.src_address = out_addr_q;
  assign out_ch.data.out_of_range = out_bad_q;

  // ---------------- checks ----------------
  `QDW_ASSERT(a_div_lockstep, divx_vld == divy_vld, "x and y dividers out of step")
  `QDW_ASSERT_IMP(a_bad_addr_zero, out_vld_q && out_bad_q, out_addr_q == '0, "bad source with nonzero address")
  `QDW_ASSERT_IMP(a_stall_blocks_input, out_vld_q && !out_ch.ready, !in_ch.ready, "input taken while output stalled")

endmodule
